/* src/efla_line_rasterizer_top_defines.svh */
// ----------------------------------------------------------------------------
// efla line rasterizer assertion macros
// shared property forms for the concurrent checks of the rasterizer
// ----------------------------------------------------------------------------
`ifndef EFLA_LINE_RASTERIZER_TOP_DEFINES_SVH
`define EFLA_LINE_RASTERIZER_TOP_DEFINES_SVH

// condition implies expression in the same cycle
`define EFLA_ASSERT_IMPLIES(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("efla assertion failed");

// condition implies expression in the next cycle
`define EFLA_ASSERT_NEXT(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("efla assertion failed");

`endif

/* src/efla_pkg.sv */
// ----------------------------------------------------------------------------
// efla package
// shared constants and width helpers of the line rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package efla_pkg;

    localparam int COORD_BITS_DEF = 8;
    localparam int PIXELS_PER_GROUP_DEF = 4;
    localparam int COLOUR_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int QUEUE_DEPTH = 2;

    // flags, start point coords, step, pixel count and colour
    function automatic int job_bits(input int cb);
        return 4 * cb + 2 * FRAC_BITS + 3;
    endfunction

    function automatic int bytes_up(input int w);
        return ((w + 7) >> 3) << 3;
    endfunction

endpackage

`default_nettype wire

/* src/efla_front.sv */
// ----------------------------------------------------------------------------
// efla front
// accepts a segment, picks the major axis and divides out the minor step
// ----------------------------------------------------------------------------
`default_nettype none

module efla_front #(
    parameter int COORD_BITS = efla_pkg::COORD_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [COORD_BITS-1:0]              start_x,
    input  wire logic [COORD_BITS-1:0]              start_y,
    input  wire logic [COORD_BITS-1:0]              end_x,
    input  wire logic [COORD_BITS-1:0]              end_y,
    input  wire logic [efla_pkg::COLOUR_BITS-1:0]   colour,
    output logic                                    job_valid,
    input  wire logic                               job_ready,
    output logic [efla_pkg::job_bits(COORD_BITS)-1:0] job_data
);
    import efla_pkg::*;

    localparam int ACC_BITS = COORD_BITS + FRAC_BITS;
    localparam int CNT_BITS = $clog2(ACC_BITS);

    typedef struct packed {
        logic                   y_major;
        logic                   dir_up;
        logic [COORD_BITS-1:0]  major_start;
        logic [COORD_BITS-1:0]  minor_start;
        logic [ACC_BITS-1:0]    step;
        logic [COORD_BITS:0]    count;
        logic [COLOUR_BITS-1:0] colour;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;

    logic                   y_major_reg;
    logic                   dir_up_reg;
    logic                   short_neg_reg;
    logic [COORD_BITS-1:0]  major_reg;
    logic [COORD_BITS-1:0]  minor_reg;
    logic [COORD_BITS-1:0]  short_abs_reg;
    logic [COORD_BITS-1:0]  long_abs_reg;
    logic [COLOUR_BITS-1:0] colour_reg;
    logic [ACC_BITS-1:0]    qd_reg, qd_next;
    logic [COORD_BITS-1:0]  rem_reg, rem_next;
    logic [CNT_BITS-1:0]    cnt_reg;

    logic [COORD_BITS:0]    dx, dy, dx_neg, dy_neg;
    logic [COORD_BITS-1:0]  abs_dx, abs_dy;
    logic                   y_major;
    logic                   long_neg, long_nz;
    logic [COORD_BITS:0]    shifted, diff;
    logic                   ge;
    logic [ACC_BITS-1:0]    q_neg;
    job_t                   job;
    logic                   accept;

    // classification of the incoming segment
    always_comb begin
        dx      = {1'b0, end_x} - {1'b0, start_x};
        dy      = {1'b0, end_y} - {1'b0, start_y};
        dx_neg  = ~dx + 1'b1;
        dy_neg  = ~dy + 1'b1;
        abs_dx  = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        abs_dy  = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        y_major = abs_dy > abs_dx;
        long_neg = y_major ? dy[COORD_BITS] : dx[COORD_BITS];
        long_nz  = y_major ? (|dy) : (|dx);
    end

    // one restoring division step per cycle
    always_comb begin
        shifted  = {rem_reg, qd_reg[ACC_BITS-1]};
        diff     = shifted - {1'b0, long_abs_reg};
        ge       = shifted >= {1'b0, long_abs_reg};
        rem_next = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
        qd_next  = {qd_reg[ACC_BITS-2:0], ge};
        q_neg    = ~qd_reg + 1'b1;
    end

    assign s_ready   = (state_reg == F_IDLE);
    assign accept    = s_valid && s_ready;
    assign job_valid = (state_reg == F_PUSH);

    always_comb begin
        job.y_major     = y_major_reg;
        job.dir_up      = dir_up_reg;
        job.major_start = major_reg;
        job.minor_start = minor_reg;
        if (short_abs_reg == '0) begin
            job.step = '0;
        end else if (short_neg_reg) begin
            job.step = q_neg;
        end else begin
            job.step = qd_reg;
        end
        job.count  = {1'b0, long_abs_reg} + 1'b1;
        job.colour = colour_reg;
    end

    assign job_data = job;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) state_next = F_DIV;
            end
            F_DIV: begin
                if (cnt_reg == '0) state_next = F_PUSH;
            end
            F_PUSH: begin
                if (job_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            y_major_reg   <= y_major;
            dir_up_reg    <= !long_neg && long_nz;
            short_neg_reg <= (y_major ? dx[COORD_BITS] : dy[COORD_BITS]) ^ long_neg;
            major_reg     <= y_major ? start_y : start_x;
            minor_reg     <= y_major ? start_x : start_y;
            short_abs_reg <= y_major ? abs_dx : abs_dy;
            long_abs_reg  <= y_major ? abs_dy : abs_dx;
            colour_reg    <= colour;
            qd_reg        <= {(y_major ? abs_dx : abs_dy), {FRAC_BITS{1'b0}}};
            rem_reg       <= '0;
            cnt_reg       <= CNT_BITS'(ACC_BITS - 1);
        end else if (state_reg == F_DIV) begin
            qd_reg  <= qd_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* src/efla_queue.sv */
// ----------------------------------------------------------------------------
// efla queue
// small job queue between the front and the stepping back end
// ----------------------------------------------------------------------------
`default_nettype none

module efla_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    import efla_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic             push, pop;

    assign in_ready  = (level_reg != LVL_W'(QUEUE_DEPTH));
    assign out_valid = (level_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

/* src/efla_back.sv */
// ----------------------------------------------------------------------------
// efla back
// steps along the major axis one pixel a cycle while no finished group waits on a held output, and packs pixel groups
// ----------------------------------------------------------------------------
`default_nettype none

module efla_back #(
    parameter int COORD_BITS       = efla_pkg::COORD_BITS_DEF,
    parameter int PIXELS_PER_GROUP = efla_pkg::PIXELS_PER_GROUP_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   job_valid,
    output logic                                        job_ready,
    input  wire logic [efla_pkg::job_bits(COORD_BITS)-1:0] job_data,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [2*PIXELS_PER_GROUP*COORD_BITS-1:0]    out_pixels,
    output logic [$clog2(PIXELS_PER_GROUP+1)-1:0]       out_count,
    output logic [efla_pkg::COLOUR_BITS-1:0]            out_colour,
    output logic                                        out_last
);
    import efla_pkg::*;

    localparam int ACC_BITS = COORD_BITS + FRAC_BITS;
    localparam int SLOT_W   = (PIXELS_PER_GROUP > 1) ? $clog2(PIXELS_PER_GROUP) : 1;
    localparam int CNT_W    = $clog2(PIXELS_PER_GROUP + 1);
    localparam logic [FRAC_BITS-1:0] HALF_PIXEL = FRAC_BITS'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic                   y_major;
        logic                   dir_up;
        logic [COORD_BITS-1:0]  major_start;
        logic [COORD_BITS-1:0]  minor_start;
        logic [ACC_BITS-1:0]    step;
        logic [COORD_BITS:0]    count;
        logic [COLOUR_BITS-1:0] colour;
    } job_t;

    job_t job;

    logic                   active_reg;
    logic                   y_major_reg;
    logic                   dir_up_reg;
    logic [COORD_BITS-1:0]  major_reg;
    logic [ACC_BITS-1:0]    acc_reg;
    logic [ACC_BITS-1:0]    step_reg;
    logic [COORD_BITS:0]    remain_reg;
    logic [COLOUR_BITS-1:0] colour_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [COORD_BITS-1:0]  bx_reg [PIXELS_PER_GROUP];
    logic [COORD_BITS-1:0]  by_reg [PIXELS_PER_GROUP];

    logic                   ovalid_reg;
    logic [COORD_BITS-1:0]  ox_reg [PIXELS_PER_GROUP];
    logic [COORD_BITS-1:0]  oy_reg [PIXELS_PER_GROUP];
    logic [CNT_W-1:0]       ocount_reg;
    logic [COLOUR_BITS-1:0] ocolour_reg;
    logic                   olast_reg;

    logic [COORD_BITS-1:0]  minor_coord, px, py;
    logic [COORD_BITS-1:0]  nx [PIXELS_PER_GROUP];
    logic [COORD_BITS-1:0]  ny [PIXELS_PER_GROUP];
    logic                   last_pix, grp_full, close_grp, out_free, adv, load;

    assign job = job_data;

    always_comb begin
        minor_coord = acc_reg[ACC_BITS-1:FRAC_BITS];
        px          = y_major_reg ? minor_coord : major_reg;
        py          = y_major_reg ? major_reg : minor_coord;
        for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
            nx[i] = (slot_reg == SLOT_W'(i)) ? px : bx_reg[i];
            ny[i] = (slot_reg == SLOT_W'(i)) ? py : by_reg[i];
        end
    end

    assign last_pix  = (remain_reg == (COORD_BITS+1)'(1));
    assign grp_full  = (slot_reg == SLOT_W'(PIXELS_PER_GROUP - 1));
    assign close_grp = last_pix || grp_full;
    assign out_free  = !ovalid_reg || out_ready;
    assign adv       = active_reg && (!close_grp || out_free);
    assign job_ready = !active_reg;
    assign load      = job_valid && !active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            if (load) begin
                active_reg <= 1'b1;
            end else if (adv && last_pix) begin
                active_reg <= 1'b0;
            end
            if (adv && close_grp) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            y_major_reg <= job.y_major;
            dir_up_reg  <= job.dir_up;
            major_reg   <= job.major_start;
            acc_reg     <= {job.minor_start, HALF_PIXEL};
            step_reg    <= job.step;
            remain_reg  <= job.count;
            colour_reg  <= job.colour;
            slot_reg    <= '0;
            for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
                bx_reg[i] <= '0;
                by_reg[i] <= '0;
            end
        end else if (adv) begin
            major_reg  <= dir_up_reg ? major_reg + 1'b1 : major_reg - 1'b1;
            acc_reg    <= dir_up_reg ? acc_reg + step_reg : acc_reg - step_reg;
            remain_reg <= remain_reg - 1'b1;
            if (close_grp) begin
                for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
                    ox_reg[i] <= nx[i];
                    oy_reg[i] <= ny[i];
                    bx_reg[i] <= '0;
                    by_reg[i] <= '0;
                end
                ocount_reg  <= CNT_W'({1'b0, slot_reg}) + CNT_W'(1);
                ocolour_reg <= colour_reg;
                olast_reg   <= last_pix;
                slot_reg    <= '0;
            end else begin
                for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
                    bx_reg[i] <= nx[i];
                    by_reg[i] <= ny[i];
                end
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
            out_pixels[(2*i)*COORD_BITS +: COORD_BITS]   = ox_reg[i];
            out_pixels[(2*i+1)*COORD_BITS +: COORD_BITS] = oy_reg[i];
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_count  = ocount_reg;
    assign out_colour = ocolour_reg;
    assign out_last   = olast_reg;

endmodule

`default_nettype wire

/* src/efla_line_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// efla line rasterizer top
// fixed-point line stepper emitting pixel groups for one segment per beat
// ----------------------------------------------------------------------------
// usage
//   input beat: one segment (two endpoints and a colour) on s_tdata
//   output beats: groups of up to PIXELS_PER_GROUP pixels in drawing order,
//     m_tlast on the final group of the segment
//   front: an accept state, a slope division of COORD_BITS+16 quotient bits (24
//     by default, one quotient bit a cycle), then a push state that holds the
//     job until the queue takes it; the front takes no new segment until then
//   back: loads a job when idle, then steps one pixel per cycle while no
//     finished group waits on a held output
//   sustained throughput per segment is set by the divider and the
//     one-pixel-a-cycle stepper
//   a two-entry job queue lets the front divide the next segment while the
//     back still steps the current one
//   reset clears all handshake state; no beats are pending afterwards
//   when m_tready is low, the held group stays and the back stops at the
//   next group boundary; the front keeps working until the queue fills
// ----------------------------------------------------------------------------
`default_nettype none

`include "efla_line_rasterizer_top_defines.svh"

module efla_line_rasterizer_top #(
    parameter int COORD_BITS       = efla_pkg::COORD_BITS_DEF,
    parameter int PIXELS_PER_GROUP = efla_pkg::PIXELS_PER_GROUP_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // start_x, start_y, end_x, end_y, colour
    input  wire logic [efla_pkg::bytes_up(4*COORD_BITS+efla_pkg::COLOUR_BITS)-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // first_x, first_y, second_x, second_y, ... per pixel slot, pixel_count,
    // pixel_colour
    output logic [efla_pkg::bytes_up(2*PIXELS_PER_GROUP*COORD_BITS
                 + $clog2(PIXELS_PER_GROUP+1) + efla_pkg::COLOUR_BITS)-1:0] m_tdata,
    // last_group
    output logic      m_tlast
);
    import efla_pkg::*;

    localparam int CNT_W   = $clog2(PIXELS_PER_GROUP + 1);
    localparam int PIX_W   = 2 * PIXELS_PER_GROUP * COORD_BITS;
    localparam int M_W     = bytes_up(PIX_W + CNT_W + COLOUR_BITS);
    localparam int JOB_W   = job_bits(COORD_BITS);

    logic             f_job_valid, f_job_ready;
    logic [JOB_W-1:0] f_job_data;
    logic             b_job_valid, b_job_ready;
    logic [JOB_W-1:0] b_job_data;

    logic [PIX_W-1:0]       back_pixels;
    logic [CNT_W-1:0]       back_count;
    logic [COLOUR_BITS-1:0] back_colour;

    efla_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .start_x   (s_tdata[0*COORD_BITS +: COORD_BITS]),
        .start_y   (s_tdata[1*COORD_BITS +: COORD_BITS]),
        .end_x     (s_tdata[2*COORD_BITS +: COORD_BITS]),
        .end_y     (s_tdata[3*COORD_BITS +: COORD_BITS]),
        .colour    (s_tdata[4*COORD_BITS +: COLOUR_BITS]),
        .job_valid (f_job_valid),
        .job_ready (f_job_ready),
        .job_data  (f_job_data)
    );

    efla_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_job_valid),
        .in_ready  (f_job_ready),
        .in_data   (f_job_data),
        .out_valid (b_job_valid),
        .out_ready (b_job_ready),
        .out_data  (b_job_data)
    );

    efla_back #(
        .COORD_BITS       (COORD_BITS),
        .PIXELS_PER_GROUP (PIXELS_PER_GROUP)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (b_job_valid),
        .job_ready  (b_job_ready),
        .job_data   (b_job_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixels (back_pixels),
        .out_count  (back_count),
        .out_colour (back_colour),
        .out_last   (m_tlast)
    );

    assign m_tdata = M_W'({back_colour, back_count, back_pixels});

    `EFLA_ASSERT_IMPLIES(a_count_range, aclk, aresetn, m_tvalid, (back_count != '0) && (back_count <= CNT_W'(PIXELS_PER_GROUP)))
    `EFLA_ASSERT_IMPLIES(a_full_groups, aclk, aresetn, m_tvalid && !m_tlast, back_count == CNT_W'(PIXELS_PER_GROUP))
    `EFLA_ASSERT_NEXT(a_front_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire
